// ----- rtl/tun_pkg.sv -----
// Shared types and constants for the triangle unit normal core.
// Used by the front, queue, lane, back and top-level modules; no dependencies.
package tun_pkg;

  localparam int CRD_W       = 24;             // Q11.12 corner coordinate
  localparam int EDGE_W      = CRD_W + 1;      // edge vector component
  localparam int PROD_W      = 2 * EDGE_W;     // edge product
  localparam int CROSS_W     = PROD_W + 1;     // signed cross component
  localparam int MAG_W       = PROD_W;         // cross magnitude, at most 2^49
  localparam int HALF_W      = MAG_W / 2;      // split for the squaring
  localparam int SQ_W        = 2 * MAG_W - 1;  // squared magnitude, at most 2^98
  localparam int SUM_W       = SQ_W + 1;       // squared length, below 2^100
  localparam int REM_W       = SUM_W + 1;      // divider partial remainder
  localparam int THR_W       = 32;
  localparam int OUT_W       = 32;             // Q1.30 result component
  localparam int QUO_W       = 63;             // floor(sq * 2^62 / sum)
  localparam int DIV_STEPS   = QUO_W;
  localparam int ROOT_W      = 64;             // integer square root datapath
  localparam int SQRT_STEPS  = ROOT_W / 2;
  localparam int MAGQ_W      = 31;             // rounded magnitude, at most 2^30
  localparam int LANE_LAT    = DIV_STEPS + SQRT_STEPS + 1;
  localparam int FRONT_DEPTH = 7;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [THR_W-1:0] THR_RESET = 32'd281;
  localparam logic [OUT_W-1:0] ONE_Q30   = 32'h4000_0000;

  // One classified triangle handed from the front to the back
  typedef struct packed {
    logic [SUM_W-1:0]     sum;
    logic [2:0][SQ_W-1:0] sq;
    logic [2:0]           neg;
    logic                 degen;
  } tun_item_t;

endpackage

// ----- rtl/tun_front.sv -----
// Front end: edge vectors, cross product, squared length and degenerate test.
// Depends on tun_pkg; feeds tun_queue with one tun_item_t per transaction.
module tun_front
  import tun_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [CRD_W-1:0] a [3],
  input  logic signed [CRD_W-1:0] b [3],
  input  logic signed [CRD_W-1:0] c [3],
  input  logic [THR_W-1:0]        thr,
  input  logic                    q_full,
  output logic                    push,
  output tun_item_t               item
);

  logic                     fen;
  logic [FRONT_DEPTH-1:0]   fv_r;
  logic signed [EDGE_W-1:0] e0_r [3];
  logic signed [EDGE_W-1:0] e1_r [3];
  logic signed [PROD_W-1:0] pa_r [3];
  logic signed [PROD_W-1:0] pb_r [3];
  logic [MAG_W-1:0]         mag_r [3];
  logic [2:0]               neg3_r, neg4_r, neg5_r, neg6_r;
  logic [PROD_W-1:0]        hh_r [3];
  logic [PROD_W-1:0]        hl_r [3];
  logic [PROD_W-1:0]        ll_r [3];
  logic [SQ_W-1:0]          sq5_r [3];
  logic [SQ_W-1:0]          sq6_r [3];
  logic [SUM_W-1:0]         sum_r;
  tun_item_t                item_r;

  // Advance unless the finished item cannot enter the queue
  assign fen      = !(fv_r[FRONT_DEPTH-1] && q_full);
  assign in_stall = !fen;
  assign push     = fv_r[FRONT_DEPTH-1] && !q_full;
  assign item     = item_r;

  // Valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (fen) begin
      fv_r <= {fv_r[FRONT_DEPTH-2:0], in_valid};
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    logic signed [CROSS_W-1:0] n;
    logic [CROSS_W-1:0]        n_abs;
    if (fen) begin
      for (int i = 0; i < 3; i++) begin
        // edge vectors from the first corner
        e0_r[i] <= {b[i][CRD_W-1], b[i]} - {a[i][CRD_W-1], a[i]};
        e1_r[i] <= {c[i][CRD_W-1], c[i]} - {a[i][CRD_W-1], a[i]};
        // cross product terms
        pa_r[i] <= e0_r[(i + 1) % 3] * e1_r[(i + 2) % 3];
        pb_r[i] <= e0_r[(i + 2) % 3] * e1_r[(i + 1) % 3];
        // cross component as sign and magnitude
        n         = {pa_r[i][PROD_W-1], pa_r[i]} - {pb_r[i][PROD_W-1], pb_r[i]};
        n_abs     = n[CROSS_W-1] ? -n : n;
        mag_r[i]  <= n_abs[MAG_W-1:0];
        neg3_r[i] <= n[CROSS_W-1];
        // square the magnitude in halves
        hh_r[i] <= PROD_W'(mag_r[i][MAG_W-1:HALF_W]) * PROD_W'(mag_r[i][MAG_W-1:HALF_W]);
        hl_r[i] <= PROD_W'(mag_r[i][MAG_W-1:HALF_W]) * PROD_W'(mag_r[i][HALF_W-1:0]);
        ll_r[i] <= PROD_W'(mag_r[i][HALF_W-1:0]) * PROD_W'(mag_r[i][HALF_W-1:0]);
        sq5_r[i] <= (SQ_W'(hh_r[i]) << (2 * HALF_W)) + (SQ_W'(hl_r[i]) << (HALF_W + 1))
                    + SQ_W'(ll_r[i]);
        sq6_r[i] <= sq5_r[i];
      end
      neg4_r <= neg3_r;
      neg5_r <= neg4_r;
      neg6_r <= neg5_r;
      // squared length
      sum_r <= SUM_W'(sq5_r[0]) + SUM_W'(sq5_r[1]) + SUM_W'(sq5_r[2]);
      // classify
      item_r.sum   <= sum_r;
      item_r.sq    <= {sq6_r[2], sq6_r[1], sq6_r[0]};
      item_r.neg   <= neg6_r;
      item_r.degen <= (sum_r == '0) || (sum_r < SUM_W'(thr));
    end
  end

endmodule

// ----- rtl/tun_queue.sv -----
// Short queue that decouples the front end from the divide and root back end.
// Depends on tun_pkg for the item type and depth.
module tun_queue
  import tun_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tun_item_t push_item,
  input  logic      pop,
  output tun_item_t head,
  output logic      full,
  output logic      empty
);

  tun_item_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r, rd_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               do_push, do_pop;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_item;
  end

endmodule

// ----- rtl/tun_lane.sv -----
// One normal component: restoring divide sq*2^62/sum, integer square root, rounding.
// Depends on tun_pkg; one bit of quotient or root per pipeline stage.
module tun_lane
  import tun_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   sq,
  input  logic [SUM_W-1:0]  sum,
  output logic [MAGQ_W-1:0] mag
);

  logic [REM_W-1:0]  rem_r [DIV_STEPS];
  logic [SUM_W-1:0]  den_r [DIV_STEPS];
  logic [QUO_W-1:0]  quo_r [DIV_STEPS];
  logic [ROOT_W-1:0] op_r  [SQRT_STEPS];
  logic [ROOT_W-1:0] res_r [SQRT_STEPS];
  logic [MAGQ_W-1:0] mag_r;

  // Divide: one quotient bit a stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [REM_W-1:0] r_in;
    logic [SUM_W-1:0] d_in;
    logic [QUO_W-1:0] q_in;
    logic             bit_q;
    if (k == 0) begin : g_first
      assign r_in = REM_W'(sq);
      assign d_in = sum;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = {rem_r[k-1][REM_W-2:0], 1'b0};
      assign d_in = den_r[k-1];
      assign q_in = quo_r[k-1];
    end
    assign bit_q = (r_in >= REM_W'(d_in));
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= bit_q ? r_in - REM_W'(d_in) : r_in;
        den_r[k] <= d_in;
        quo_r[k] <= {q_in[QUO_W-2:0], bit_q};
      end
    end
  end

  // Square root: one root bit a stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [ROOT_W-1:0] BIT_J = ROOT_W'(1) << (ROOT_W - 2 - 2 * j);
    logic [ROOT_W-1:0] op_in, res_in, trial;
    if (j == 0) begin : g_first
      assign op_in  = ROOT_W'(quo_r[DIV_STEPS-1]);
      assign res_in = '0;
    end else begin : g_next
      assign op_in  = op_r[j-1];
      assign res_in = res_r[j-1];
    end
    assign trial = res_in + BIT_J;
    always_ff @(posedge clk) begin
      if (en) begin
        if (op_in >= trial) begin
          op_r[j]  <= op_in - trial;
          res_r[j] <= (res_in >> 1) + BIT_J;
        end else begin
          op_r[j]  <= op_in;
          res_r[j] <= res_in >> 1;
        end
      end
    end
  end

  // Round half up on the doubled root and clamp at one
  always_ff @(posedge clk) begin
    logic [OUT_W:0] half;
    if (en) begin
      half = ({1'b0, res_r[SQRT_STEPS-1][OUT_W-1:0]} + 1'b1) >> 1;
      if (half > (OUT_W + 1)'(ONE_Q30)) begin
        mag_r <= ONE_Q30[MAGQ_W-1:0];
      end else begin
        mag_r <= half[MAGQ_W-1:0];
      end
    end
  end

  assign mag = mag_r;

endmodule

// ----- rtl/tun_back.sv -----
// Back end: three normalising lanes, flag pipeline, sign and fallback output.
// Depends on tun_pkg and tun_lane; pops tun_item_t transactions from tun_queue.
module tun_back
  import tun_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  tun_item_t               head,
  input  logic                    q_empty,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] nrm [3],
  output logic                    degen
);

  logic                en;
  logic [LANE_LAT-1:0] v_r;
  logic [2:0]          neg_r   [LANE_LAT];
  logic                degen_r [LANE_LAT];
  logic [MAGQ_W-1:0]   mag     [3];

  // Hold the whole pipe while a result waits
  assign en        = !(out_valid && out_stall);
  assign pop       = en && !q_empty;
  assign out_valid = v_r[LANE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LANE_LAT-2:0], pop};
    end
  end

  // Carry signs and the degenerate flag alongside the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0]   <= head.neg;
      degen_r[0] <= head.degen;
      for (int i = 1; i < LANE_LAT; i++) begin
        neg_r[i]   <= neg_r[i-1];
        degen_r[i] <= degen_r[i-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    tun_lane u_lane (
      .clk (clk),
      .en  (en),
      .sq  (head.sq[i]),
      .sum (head.sum),
      .mag (mag[i])
    );
  end

  // Apply sign, or substitute the fallback normal
  always_comb begin
    logic [OUT_W-1:0] m;
    for (int i = 0; i < 3; i++) begin
      m = OUT_W'(mag[i]);
      nrm[i] = neg_r[LANE_LAT-1][i] ? -m : m;
    end
    degen = degen_r[LANE_LAT-1];
    if (degen) begin
      nrm[0] = '0;
      nrm[1] = '0;
      nrm[2] = ONE_Q30;
    end
  end

endmodule

// ----- rtl/triangle_unit_normal_core.sv -----
// Top level of the triangle unit normal core: threshold register, front, queue, back.
// Depends on tun_pkg, tun_front, tun_queue, tun_lane and tun_back.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall  in_{a,b,c}_{x,y,z}, signed Q11.12
//   out_      output     out_valid/out_stall  out_normal_{x,y,z} Q1.30, out_degenerate
//   cfg_      input      cfg_wen              cfg_data, min squared length
//
// One triangle is accepted per cycle while in_stall is low; each passes through the
// 7 front stages (the first loaded at the accepting edge), the queue storage, then 63
// divider, 32 root and one rounding stage per lane.
// Synchronous active-low reset clears valids, queue pointers and sets the threshold
// to 281. A stalled result holds the whole back end; the four-entry queue then fills
// and the front stalls the input only when its last stage cannot enter the queue.
module triangle_unit_normal_core
  import tun_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [CRD_W-1:0] in_a_x,
  input  logic signed [CRD_W-1:0] in_a_y,
  input  logic signed [CRD_W-1:0] in_a_z,
  input  logic signed [CRD_W-1:0] in_b_x,
  input  logic signed [CRD_W-1:0] in_b_y,
  input  logic signed [CRD_W-1:0] in_b_z,
  input  logic signed [CRD_W-1:0] in_c_x,
  input  logic signed [CRD_W-1:0] in_c_y,
  input  logic signed [CRD_W-1:0] in_c_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_normal_x,
  output logic signed [OUT_W-1:0] out_normal_y,
  output logic signed [OUT_W-1:0] out_normal_z,
  output logic                    out_degenerate,
  input  logic                    cfg_wen,
  input  logic [THR_W-1:0]        cfg_data
);

  logic [THR_W-1:0]        min_sq_len_r;
  logic signed [CRD_W-1:0] a [3];
  logic signed [CRD_W-1:0] b [3];
  logic signed [CRD_W-1:0] c [3];
  logic                    push, pop, q_full, q_empty;
  tun_item_t               push_item, head;
  logic signed [OUT_W-1:0] nrm [3];

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_sq_len_r <= THR_RESET;
    end else if (cfg_wen) begin
      min_sq_len_r <= cfg_data;
    end
  end

  assign a = '{in_a_x, in_a_y, in_a_z};
  assign b = '{in_b_x, in_b_y, in_b_z};
  assign c = '{in_c_x, in_c_y, in_c_z};

  tun_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .a        (a),
    .b        (b),
    .c        (c),
    .thr      (min_sq_len_r),
    .q_full   (q_full),
    .push     (push),
    .item     (push_item)
  );

  tun_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  tun_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .nrm       (nrm),
    .degen     (out_degenerate)
  );

  assign out_normal_x = nrm[0];
  assign out_normal_y = nrm[1];
  assign out_normal_z = nrm[2];

  // Fallback normal accompanies the flag
  a_degen_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_normal_x == '0 && out_normal_y == '0 && out_normal_z == ONE_Q30)
    else $error("degenerate result without fallback normal");

  // Components never exceed one in magnitude
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_normal_x <= $signed(ONE_Q30) && out_normal_x >= -$signed(ONE_Q30) &&
      out_normal_y <= $signed(ONE_Q30) && out_normal_y >= -$signed(ONE_Q30) &&
      out_normal_z <= $signed(ONE_Q30) && out_normal_z >= -$signed(ONE_Q30))
    else $error("normal component out of range");

  // The front holds back a finished item only while the queue is full
  a_push_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_full)
    else $error("input stalled with room in the queue");

endmodule

// ----- sim/triangle_unit_normal_core_tb.sv -----
// Self-checking testbench for triangle_unit_normal_core: drives triangles, predicts
// each unit normal with exact wide integer arithmetic and checks every result.
// Depends on tun_pkg and the RTL of the core only.
module triangle_unit_normal_core_tb
  import tun_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [CRD_W-1:0] corners_t [9];

  typedef struct {
    logic signed [OUT_W-1:0] nx;
    logic signed [OUT_W-1:0] ny;
    logic signed [OUT_W-1:0] nz;
    logic                    degen;
  } normal_t;

  localparam int DRAIN_CYCLES = 150;
  localparam int HOLD_CYCLES  = 400;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [CRD_W-1:0] in_a_x, in_a_y, in_a_z;
  logic signed [CRD_W-1:0] in_b_x, in_b_y, in_b_z;
  logic signed [CRD_W-1:0] in_c_x, in_c_y, in_c_z;
  logic out_valid;
  logic out_stall;
  logic signed [OUT_W-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_degenerate;
  logic cfg_wen;
  logic [THR_W-1:0] cfg_data;

  normal_t          expected_normals[$];
  logic [THR_W-1:0] threshold;
  int               send_idle_pct;
  int               stall_pct;
  int               hold_req;
  int               hold_seen;
  int               hold_left;
  int               mismatches;

  triangle_unit_normal_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z),
    .in_c_x(in_c_x), .in_c_y(in_c_y), .in_c_z(in_c_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z), .out_degenerate(out_degenerate),
    .cfg_wen(cfg_wen), .cfg_data(cfg_data)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // One Q1.30 component: largest f with f^2 * S <= m^2 * 2^60, then round to nearest
  function automatic logic [OUT_W-1:0] unit_part(longint comp, logic [191:0] sum_sq);
    logic [191:0] mag, msq, lhs, kk;
    logic [63:0]  f, t;
    f   = 0;
    mag = (comp < 0) ? -comp : comp;
    msq = mag * mag;
    for (int b = 30; b >= 0; b--) begin
      t   = f | (64'd1 << b);
      kk  = t;
      lhs = kk * kk * sum_sq;
      if (t <= 64'd1073741824 && lhs <= (msq << 60)) f = t;
    end
    kk  = 2 * f + 1;
    lhs = kk * kk * sum_sq;
    if (f < 64'd1073741824 && lhs <= (msq << 62)) f = f + 1;
    if (comp < 0) f = -f;
    return f[OUT_W-1:0];
  endfunction

  function automatic normal_t face_normal(corners_t p, logic [THR_W-1:0] thr);
    longint       e0x, e0y, e0z, e1x, e1y, e1z, nx, ny, nz;
    logic [191:0] mx, my, mz, sum_sq;
    normal_t      r;
    e0x = longint'(p[3]) - longint'(p[0]);
    e0y = longint'(p[4]) - longint'(p[1]);
    e0z = longint'(p[5]) - longint'(p[2]);
    e1x = longint'(p[6]) - longint'(p[0]);
    e1y = longint'(p[7]) - longint'(p[1]);
    e1z = longint'(p[8]) - longint'(p[2]);
    nx  = e0y * e1z - e0z * e1y;
    ny  = e0z * e1x - e0x * e1z;
    nz  = e0x * e1y - e0y * e1x;
    mx  = (nx < 0) ? -nx : nx;
    my  = (ny < 0) ? -ny : ny;
    mz  = (nz < 0) ? -nz : nz;
    sum_sq = mx * mx + my * my + mz * mz;
    if (sum_sq == 0 || sum_sq < thr) begin
      r.nx = 0;
      r.ny = 0;
      r.nz = ONE_Q30;
      r.degen = 1'b1;
    end else begin
      r.nx = unit_part(nx, sum_sq);
      r.ny = unit_part(ny, sum_sq);
      r.nz = unit_part(nz, sum_sq);
      r.degen = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Send one triangle; entered and left at a rising edge
  task automatic send_triangle(corners_t p);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_a_x <= p[0]; in_a_y <= p[1]; in_a_z <= p[2];
    in_b_x <= p[3]; in_b_y <= p[4]; in_b_z <= p[5];
    in_c_x <= p[6]; in_c_y <= p[7]; in_c_z <= p[8];
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    expected_normals.push_back(face_normal(p, threshold));
  endtask

  // Wait until every result is back and the pipeline is empty
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_normals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    cfg_wen  <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_wen  <= 1'b0;
    threshold = v;
    @(posedge clk);
  endtask

  function automatic logic signed [CRD_W-1:0] rand_coord();
    return CRD_W'($urandom);
  endfunction

  // Mix of full-range, small and collinear triangles
  function automatic corners_t rand_triangle();
    corners_t p;
    int kind, span, k;
    kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) p[i] = rand_coord();
    if (kind >= 4) begin
      span = 1 << $urandom_range(16, 1);
      for (int i = 3; i < 9; i++)
        p[i] = CRD_W'(p[i % 3] + $signed($urandom_range(2 * span)) - span);
    end
    if (kind == 9) begin
      k = $urandom_range(3);
      for (int i = 0; i < 3; i++) p[6 + i] = CRD_W'(p[i] + k * (p[3 + i] - p[i]));
    end
    return p;
  endfunction

  task automatic test_directed();
    corners_t p;
    localparam logic signed [CRD_W-1:0] MAXC = 24'sh7FFFFF;
    localparam logic signed [CRD_W-1:0] MINC = -24'sh800000;
    send_idle_pct = 0;
    stall_pct = 0;
    // all corners at one point
    p = '{default: 0};                                   send_triangle(p);
    // unit right triangle, both windings
    p = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0};              send_triangle(p);
    p = '{0, 0, 0, 0, 4096, 0, 4096, 0, 0};              send_triangle(p);
    // each axis as normal
    p = '{0, 0, 0, 0, 4096, 0, 0, 0, 4096};              send_triangle(p);
    p = '{0, 0, 0, 0, 0, 4096, 4096, 0, 0};              send_triangle(p);
    // extreme coordinates
    p = '{MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MINC}; send_triangle(p);
    p = '{MAXC, MAXC, MAXC, MINC, MAXC, MAXC, MAXC, MINC, MINC}; send_triangle(p);
    p = '{MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC, MAXC, MINC}; send_triangle(p);
    p = '{MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MINC, MAXC}; send_triangle(p);
    // collinear corners
    p = '{100, 200, 300, 200, 400, 600, 300, 600, 900};  send_triangle(p);
    p = '{MINC, MINC, MINC, 0, 0, 0, MAXC, MAXC, MAXC};  send_triangle(p);
    // around the reset threshold: lengths 1, 16 (below) and 17 (above)
    p = '{5, 5, 5, 6, 5, 5, 5, 6, 5};                    send_triangle(p);
    p = '{0, 0, 0, 4, 0, 0, 0, 4, 0};                    send_triangle(p);
    p = '{0, 0, 0, 17, 0, 0, 0, 1, 0};                   send_triangle(p);
    // oblique triangles
    p = '{1, 2, 3, -70000, 9000, 123, 4567, -890, 77777}; send_triangle(p);
    p = '{-3, 7, 11, 2, -5, 13, 17, 19, -23};            send_triangle(p);
    p = '{4096, 4096, 4096, 8192, 4096, 4096, 4096, 8192, 4096}; send_triangle(p);
    drain();
  endtask

  task automatic test_random(int count, int idle_pct, int stall_level);
    send_idle_pct = idle_pct;
    stall_pct = stall_level;
    repeat (count) send_triangle(rand_triangle());
    drain();
  endtask

  // Hold the output for a long stretch while triangles keep coming
  task automatic test_backpressure(int count);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req++;
    repeat (count) send_triangle(rand_triangle());
    drain();
  endtask

  // Receiver stall: random level plus a counted long hold-off
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    normal_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_normals.size() == 0) begin
        report_mismatch("unexpected result", out_normal_x, 0);
      end else begin
        want = expected_normals.pop_front();
        if (out_normal_x !== want.nx) report_mismatch("normal_x", out_normal_x, want.nx);
        if (out_normal_y !== want.ny) report_mismatch("normal_y", out_normal_y, want.ny);
        if (out_normal_z !== want.nz) report_mismatch("normal_z", out_normal_z, want.nz);
        if (out_degenerate !== want.degen)
          report_mismatch("degenerate", out_degenerate, want.degen);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z, in_c_x, in_c_y, in_c_z} = '0;
    cfg_wen = 1'b0;
    cfg_data = '0;
    out_stall = 1'b0;
    threshold = THR_RESET;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_left = 0;
    mismatches = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(400, 0, 0);
    write_threshold('0);
    test_directed();
    test_random(350, 60, 0);
    write_threshold('1);
    test_directed();
    test_random(350, 0, 60);
    write_threshold($urandom);
    test_random(350, 16, 16);
    write_threshold(THR_RESET);
    test_backpressure(100);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- triangle_unit_normal_core.f -----
rtl/tun_pkg.sv
rtl/tun_front.sv
rtl/tun_queue.sv
rtl/tun_lane.sv
rtl/tun_back.sv
rtl/triangle_unit_normal_core.sv
sim/triangle_unit_normal_core_tb.sv
